// ===== rtl/core/hse_pkg.sv =====
// ----------------------------------------------------------------------------
// hse_pkg
// Shared widths, store entry layout and compare-select codes for the heap
// sort engine.
// ----------------------------------------------------------------------------
package hse_pkg;

  localparam int unsigned MAX_ITEMS = 64;
  localparam int unsigned SCORE_W   = 16;
  localparam int unsigned ADDR_W    = 6;   // store depth 64
  localparam int unsigned CNT_W     = 7;   // holds 0..64

  // score in the low bits, arrival tag above it
  typedef struct packed {
    logic [ADDR_W-1:0]  tag;
    logic [SCORE_W-1:0] score;
  } entry_t;

  // which of node / left child / right child holds the largest score
  typedef logic [1:0] sel_t;
  localparam sel_t SEL_NODE  = 2'd0;
  localparam sel_t SEL_LEFT  = 2'd1;
  localparam sel_t SEL_RIGHT = 2'd2;

endpackage

// ===== rtl/core/hse_ram.sv =====
// ----------------------------------------------------------------------------
// hse_ram
// Entry store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module hse_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [hse_pkg::ADDR_W-1:0] waddr_i,
  input  hse_pkg::entry_t            wdata_i,
  input  logic [hse_pkg::ADDR_W-1:0] raddr_a_i,
  input  logic [hse_pkg::ADDR_W-1:0] raddr_b_i,
  output hse_pkg::entry_t            rdata_a_o,
  output hse_pkg::entry_t            rdata_b_o
);

  hse_pkg::entry_t mem_q [2**hse_pkg::ADDR_W];
  hse_pkg::entry_t rd_a_q;
  hse_pkg::entry_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_a_q <= mem_q[raddr_a_i];
    rd_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

// ===== rtl/core/hse_cmp.sv =====
// ----------------------------------------------------------------------------
// hse_cmp
// Shared compare unit: picks the largest of a node and its two children,
// strict greater-than, so the node wins ties and the left child beats an
// equal right child.
// ----------------------------------------------------------------------------
module hse_cmp (
  input  logic [hse_pkg::SCORE_W-1:0] cur_i,
  input  logic [hse_pkg::SCORE_W-1:0] left_i,
  input  logic [hse_pkg::SCORE_W-1:0] right_i,
  input  logic                        left_ok_i,
  input  logic                        right_ok_i,
  output hse_pkg::sel_t               sel_o
);

  logic [hse_pkg::SCORE_W-1:0] big;
  hse_pkg::sel_t               sel;

  always_comb begin
    big = cur_i;
    sel = hse_pkg::SEL_NODE;
    if (left_ok_i && (left_i > big)) begin
      big = left_i;
      sel = hse_pkg::SEL_LEFT;
    end
    if (right_ok_i && (right_i > big)) begin
      sel = hse_pkg::SEL_RIGHT;
    end
  end

  assign sel_o = sel;

endmodule

// ===== rtl/core/heap_sort_engine.sv =====
// Loading takes one item per cycle. On the closing item the sort runs with input
// ready low: a build sift reads its start node (ST_LOAD, ST_LOADW), an extraction
// swaps root and tail (ST_XRD, ST_XWR), then each level reads and compares both
// children (ST_CHILD, ST_CMP). Results then leave through the store's read path.
// Throughput is bounded by the single store write port and shared comparator.
// Reset clears state, item count, flags, output valid; store undefined till loaded.
// ----------------------------------------------------------------------------
// heap_sort_engine
// Collects scores, heap sorts them in place and streams them out in
// ascending order with their arrival positions.
// ----------------------------------------------------------------------------
module heap_sort_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] score
  input  logic        s_axis_tlast_i,   // last_item
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [15:0] sorted_score, [21:16] source_index
  output logic        m_axis_tlast_o,   // last_result
  output logic        m_axis_tuser_o    // [0] overflow
);

  localparam int unsigned AW = hse_pkg::ADDR_W;
  localparam int unsigned CW = hse_pkg::CNT_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_LOAD  = 4'd1;  // read the sift start node
  localparam logic [3:0] ST_LOADW = 4'd2;
  localparam logic [3:0] ST_CHILD = 4'd3;  // read both children
  localparam logic [3:0] ST_CMP   = 4'd4;
  localparam logic [3:0] ST_XRD   = 4'd5;  // read root and tail
  localparam logic [3:0] ST_XWR   = 4'd6;
  localparam logic [3:0] ST_ORD   = 4'd7;
  localparam logic [3:0] ST_OLD   = 4'd8;

  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic          build_q, build_d;
  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] k_q, k_d;
  logic [AW-1:0] node_q, node_d;
  logic [AW-1:0] idx_q, idx_d;
  hse_pkg::entry_t cur_q, cur_d;

  logic          ovalid_q, ovalid_d;
  hse_pkg::entry_t odata_q, odata_d;
  logic          olast_q, olast_d;
  logic          ouser_q, ouser_d;

  logic            we;
  logic [AW-1:0]   waddr;
  hse_pkg::entry_t wdata;
  logic [AW-1:0]   raddr_a, raddr_b;
  hse_pkg::entry_t rdata_a, rdata_b;

  logic [CW-1:0] left;
  logic [AW-1:0] right_addr;
  logic          left_ok, right_ok;
  hse_pkg::sel_t sel;
  logic          in_xfer, out_xfer, stored, sift_done;
  logic [CW-1:0] n_new, k_next;

  hse_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign left       = {node_q, 1'b1};
  assign right_addr = left[AW-1:0] + AW'(1);
  assign left_ok    = left < len_q;
  assign right_ok   = ({1'b0, left} + (CW+1)'(1)) < {1'b0, len_q};

  hse_cmp u_cmp (
    .cur_i      (cur_q.score),
    .left_i     (rdata_a.score),
    .right_i    (rdata_b.score),
    .left_ok_i  (left_ok),
    .right_ok_i (right_ok),
    .sel_o      (sel)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer = ovalid_q && m_axis_tready_i;
  assign stored   = cnt_q < CW'(hse_pkg::MAX_ITEMS);
  assign n_new    = cnt_q + CW'(stored);
  assign k_next   = k_q - CW'(1);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    build_d  = build_q;
    len_d    = len_q;
    k_d      = k_q;
    node_d   = node_q;
    idx_d    = idx_q;
    cur_d    = cur_q;
    ovalid_d = ovalid_q && !out_xfer;
    odata_d  = odata_q;
    olast_d  = olast_q;
    ouser_d  = ouser_q;
    we       = 1'b0;
    waddr    = node_q;
    wdata    = cur_q;
    raddr_a  = node_q;
    raddr_b  = right_addr;
    sift_done = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (stored) begin
            we          = 1'b1;
            waddr       = cnt_q[AW-1:0];
            wdata.tag   = cnt_q[AW-1:0];
            wdata.score = s_axis_tdata_i;
          end else begin
            ovf_d = 1'b1;
          end
          cnt_d = n_new;
          if (s_axis_tlast_i) begin
            idx_d = '0;
            if (n_new >= CW'(2)) begin
              build_d = 1'b1;
              len_d   = n_new;
              k_d     = n_new >> 1;
              node_d  = AW'((n_new >> 1) - CW'(1));
              state_d = ST_LOAD;
            end else begin
              state_d = ST_ORD;
            end
          end
        end
      end
      ST_LOAD: begin
        raddr_a = node_q;
        state_d = ST_LOADW;
      end
      ST_LOADW: begin
        cur_d   = rdata_a;
        state_d = ST_CHILD;
      end
      ST_CHILD: begin
        raddr_a = left[AW-1:0];
        raddr_b = right_addr;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        // the sifted entry rides in cur_q; the larger child moves up
        we = 1'b1;
        case (sel)
          hse_pkg::SEL_LEFT: begin
            wdata   = rdata_a;
            node_d  = left[AW-1:0];
            state_d = ST_CHILD;
          end
          hse_pkg::SEL_RIGHT: begin
            wdata   = rdata_b;
            node_d  = right_addr;
            state_d = ST_CHILD;
          end
          default: begin
            wdata     = cur_q;
            sift_done = 1'b1;
          end
        endcase
        if (sift_done) begin
          if (build_q) begin
            if (k_q == CW'(1)) begin
              build_d = 1'b0;
              k_d     = cnt_q;
              state_d = ST_XRD;
            end else begin
              k_d     = k_next;
              node_d  = AW'(k_next - CW'(1));
              state_d = ST_LOAD;
            end
          end else begin
            k_d = k_next;
            if (k_next > CW'(1)) begin
              state_d = ST_XRD;
            end else begin
              idx_d   = '0;
              state_d = ST_ORD;
            end
          end
        end
      end
      ST_XRD: begin
        raddr_a = '0;
        raddr_b = AW'(k_q - CW'(1));
        state_d = ST_XWR;
      end
      ST_XWR: begin
        // root goes to the tail, tail entry sifts down from the root
        we      = 1'b1;
        waddr   = AW'(k_q - CW'(1));
        wdata   = rdata_a;
        cur_d   = rdata_b;
        node_d  = '0;
        len_d   = k_q - CW'(1);
        state_d = ST_CHILD;
      end
      ST_ORD: begin
        raddr_a = idx_q;
        if (!ovalid_q || m_axis_tready_i) begin
          state_d = ST_OLD;
        end
      end
      ST_OLD: begin
        ovalid_d = 1'b1;
        odata_d  = rdata_a;
        ouser_d  = ovf_q;
        olast_d  = ({1'b0, idx_q} == (cnt_q - CW'(1)));
        if ({1'b0, idx_q} == (cnt_q - CW'(1))) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          idx_d   = idx_q + AW'(1);
          state_d = ST_ORD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      build_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      build_q  <= build_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    k_q     <= k_d;
    node_q  <= node_d;
    idx_q   <= idx_d;
    cur_q   <= cur_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
    ouser_q <= ouser_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {2'b00, odata_q.tag, odata_q.score};
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = ouser_q;

endmodule
